// ----- rtl/core/adp_pkg.sv -----
// Shared types and constants for the announcement datagram parser.
`timescale 1ns / 1ps

package adp_pkg;

  // Default upper bound on the node id and address text lengths
  localparam int unsigned ADP_MAX_ID_BYTES = 63;

  // Bytes ahead of the node id: magic, version, lengths, spare, gen, seq, port
  localparam int unsigned FIXED_BYTES = 26;

  localparam logic [7:0] COUNT_MAX    = 8'hFF;
  localparam logic [7:0] VERSION_BYTE = 8'h01;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;

  // "ARD1"
  localparam logic [7:0] MAGIC [4] = '{8'h41, 8'h52, 8'h44, 8'h31};

  typedef enum logic [3:0] {
    REASON_OK       = 4'd0,
    REASON_SHORT    = 4'd1,
    REASON_MAGIC    = 4'd2,
    REASON_VERSION  = 4'd3,
    REASON_LENGTHS  = 4'd4,
    REASON_SIZE     = 4'd5,
    REASON_GEN      = 4'd6,
    REASON_SEQ      = 4'd7,
    REASON_ADDRESS  = 4'd8
  } reason_e;

  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  id_byte;
    logic [5:0]  id_index;
    logic        accepted;
    reason_e     reason;
    logic [63:0] generation;
    logic [63:0] sequence_res;
    logic [15:0] rpc_port;
    logic [31:0] ipv4_address;
    logic [5:0]  id_length;
  } adp_result_t;

endpackage

// ----- rtl/core/adp_parser.sv -----
// Per-datagram parse state and the per-word decode that produces a result.
`timescale 1ns / 1ps

module adp_parser #(
  parameter int unsigned MAX_ID_BYTES = adp_pkg::ADP_MAX_ID_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_i,
  input  logic                last_i,
  output logic                res_valid_o,
  output adp_pkg::adp_result_t res_o
);
  import adp_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_ID_BYTES);
  localparam logic [7:0] Fixed8 = 8'(FIXED_BYTES);

  logic [7:0]  byte_count_q, byte_count_d;
  reason_e     header_err_q, header_err_d;
  logic [7:0]  node_len_q, node_len_d;
  logic [7:0]  addr_len_q, addr_len_d;
  logic [63:0] gen_q, gen_d;
  logic [63:0] seq_q, seq_d;
  logic [15:0] port_q, port_d;
  logic [7:0]  octet_val_q, octet_val_d;
  logic [1:0]  octet_dig_q, octet_dig_d;
  logic [2:0]  octet_num_q, octet_num_d;
  logic        addr_bad_q, addr_bad_d;
  logic        addr_end_q, addr_end_d;
  logic [31:0] addr_acc_q, addr_acc_d;

  logic [7:0]  pos;
  logic [8:0]  node_end;
  logic [9:0]  addr_end;
  logic [9:0]  total;
  logic [11:0] digit_val;
  logic [2:0]  octet_num_inc;
  logic        is_digit;
  logic        id_out;
  logic        addr_ok;
  logic [7:0]  count_new;
  reason_e     reason;

  assign pos           = byte_count_q;
  assign node_end      = 9'(FIXED_BYTES) + {1'b0, node_len_q};
  assign addr_end      = {1'b0, node_end} + {2'b00, addr_len_q};
  assign is_digit      = (data_i >= CHAR_ZERO) && (data_i <= CHAR_NINE);
  // value * 10 + digit, as shift-add
  assign digit_val     = {1'b0, octet_val_q, 3'b000} + {3'b000, octet_val_q, 1'b0}
                       + {8'h00, data_i[3:0]};
  assign octet_num_inc = octet_num_q + 3'd1;
  assign count_new     = (byte_count_q != COUNT_MAX) ? byte_count_q + 8'd1 : byte_count_q;

  // Next-state decode
  always_comb begin
    byte_count_d = count_new;
    header_err_d = header_err_q;
    node_len_d   = node_len_q;
    addr_len_d   = addr_len_q;
    gen_d        = gen_q;
    seq_d        = seq_q;
    port_d       = port_q;
    octet_val_d  = octet_val_q;
    octet_dig_d  = octet_dig_q;
    octet_num_d  = octet_num_q;
    addr_bad_d   = addr_bad_q;
    addr_end_d   = addr_end_q;
    addr_acc_d   = addr_acc_q;
    id_out       = 1'b0;

    if (pos < 8'd4) begin
      if (data_i != MAGIC[pos[1:0]] && header_err_q == REASON_OK) begin
        header_err_d = REASON_MAGIC;
      end
    end else if (pos == 8'd4) begin
      if (data_i != VERSION_BYTE && header_err_q == REASON_OK) begin
        header_err_d = REASON_VERSION;
      end
    end else if (pos == 8'd5 || pos == 8'd6) begin
      if (pos == 8'd5) begin
        node_len_d = data_i;
      end else begin
        addr_len_d = data_i;
      end
      if ((data_i == 8'd0 || data_i > MaxLen) && header_err_q == REASON_OK) begin
        header_err_d = REASON_LENGTHS;
      end
    end else if (pos >= 8'd8 && pos < 8'd16) begin
      gen_d = {gen_q[55:0], data_i};
    end else if (pos >= 8'd16 && pos < 8'd24) begin
      seq_d = {seq_q[55:0], data_i};
    end else if (pos >= 8'd24 && pos < Fixed8) begin
      port_d = {port_q[7:0], data_i};
    end else if (pos >= Fixed8 && pos != COUNT_MAX && header_err_q == REASON_OK) begin
      if ({1'b0, pos} < node_end) begin
        id_out = 1'b1;
      end else if ({2'b00, pos} < addr_end && !addr_bad_q && !addr_end_q) begin
        // address text character
        if (data_i == CHAR_NUL) begin
          addr_end_d = 1'b1;
        end else if (is_digit) begin
          if (octet_dig_q != 2'd0 && octet_val_q == 8'd0) begin
            addr_bad_d = 1'b1;            // leading zero
          end else if (digit_val > 12'd255) begin
            addr_bad_d = 1'b1;
          end else begin
            if (octet_dig_q == 2'd0) begin
              octet_num_d = octet_num_inc;
            end
            if (octet_dig_q == 2'd0 && octet_num_inc > 3'd4) begin
              addr_bad_d = 1'b1;          // fifth octet
            end else begin
              octet_val_d = digit_val[7:0];
              if (octet_dig_q != 2'd3) begin
                octet_dig_d = octet_dig_q + 2'd1;
              end
            end
          end
        end else if (data_i == CHAR_DOT) begin
          if (octet_dig_q == 2'd0 || octet_num_q >= 3'd4) begin
            addr_bad_d = 1'b1;
          end else begin
            addr_acc_d  = {addr_acc_q[23:0], octet_val_q};
            octet_val_d = 8'd0;
            octet_dig_d = 2'd0;
          end
        end else begin
          addr_bad_d = 1'b1;
        end
      end
    end
  end

  // Verdict, judged on the state as this word leaves it
  always_comb begin
    logic [9:0] count_ext;
    count_ext = {2'b00, count_new};
    total   = 10'(FIXED_BYTES) + {2'b00, node_len_d} + {2'b00, addr_len_d};
    addr_ok = !addr_bad_d && octet_num_d == 3'd4 && octet_dig_d != 2'd0;
    if (count_new < Fixed8) begin
      reason = REASON_SHORT;
    end else if (header_err_d != REASON_OK) begin
      reason = header_err_d;
    end else if (count_ext != total) begin
      reason = REASON_SIZE;
    end else if (gen_d == 64'd0) begin
      reason = REASON_GEN;
    end else if (seq_d == 64'd0) begin
      reason = REASON_SEQ;
    end else if (!addr_ok) begin
      reason = REASON_ADDRESS;
    end else begin
      reason = REASON_OK;
    end
  end

  // Result word
  always_comb begin
    res_o       = '0;
    res_valid_o = 1'b0;
    if (last_i) begin
      res_valid_o        = 1'b1;
      res_o.is_verdict   = 1'b1;
      res_o.accepted     = (reason == REASON_OK);
      res_o.reason       = reason;
      res_o.generation   = gen_d;
      res_o.sequence_res = seq_d;
      res_o.rpc_port     = port_d;
      res_o.ipv4_address = (reason == REASON_OK) ? {addr_acc_d[23:0], octet_val_d} : 32'd0;
      res_o.id_length    = node_len_d[5:0];
    end else if (id_out) begin
      res_valid_o    = 1'b1;
      res_o.id_byte  = data_i;
      res_o.id_index = 6'(pos - Fixed8);
    end
  end

  // The final byte of a datagram returns the parse state to its start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      header_err_q <= REASON_OK;
      node_len_q   <= '0;
      addr_len_q   <= '0;
      gen_q        <= '0;
      seq_q        <= '0;
      port_q       <= '0;
      octet_val_q  <= '0;
      octet_dig_q  <= '0;
      octet_num_q  <= '0;
      addr_bad_q   <= 1'b0;
      addr_end_q   <= 1'b0;
      addr_acc_q   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        byte_count_q <= '0;
        header_err_q <= REASON_OK;
        node_len_q   <= '0;
        addr_len_q   <= '0;
        gen_q        <= '0;
        seq_q        <= '0;
        port_q       <= '0;
        octet_val_q  <= '0;
        octet_dig_q  <= '0;
        octet_num_q  <= '0;
        addr_bad_q   <= 1'b0;
        addr_end_q   <= 1'b0;
        addr_acc_q   <= '0;
      end else begin
        byte_count_q <= byte_count_d;
        header_err_q <= header_err_d;
        node_len_q   <= node_len_d;
        addr_len_q   <= addr_len_d;
        gen_q        <= gen_d;
        seq_q        <= seq_d;
        port_q       <= port_d;
        octet_val_q  <= octet_val_d;
        octet_dig_q  <= octet_dig_d;
        octet_num_q  <= octet_num_d;
        addr_bad_q   <= addr_bad_d;
        addr_end_q   <= addr_end_d;
        addr_acc_q   <= addr_acc_d;
      end
    end
  end

  // A verdict leaves the parser clean for the next datagram
  a_clear_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> byte_count_q == 8'd0 && header_err_q == REASON_OK)
    else $error("parse state not cleared after verdict");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_i && byte_count_q != COUNT_MAX
    |=> byte_count_q == $past(byte_count_q) + 8'd1)
    else $error("byte count did not advance");

  a_id_needs_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.is_verdict |-> header_err_q == REASON_OK && pos >= Fixed8)
    else $error("id word out of a bad or short header");

endmodule

// ----- rtl/core/announcement_datagram_parser.sv -----
// Top level of the announcement datagram parser: handshake stages around the parser.
`timescale 1ns / 1ps

// Usage
//   Input channel: one datagram byte per word (data_byte_i) with
//   end_of_datagram_i set on the final byte; in_valid_i / in_ready_o.
//   Output channel: out_valid_o / out_ready_i. Each node id byte comes out
//   as an id word (is_verdict_o = 0, id_byte_o, id_index_o) if the header
//   checks passed. The final byte yields one verdict word (is_verdict_o = 1)
//   carrying accepted_o, reject_reason_o, generation_o, sequence_res_o,
//   rpc_port_o, ipv4_address_o and id_length_o. Other bytes yield no word.
//   Stages: a byte taken into the input stage has its word, if any,
//   registered in the result stage (two register stages: input, result).
//   Throughput: one byte per cycle while output words are taken; all per-byte
//   decode is one pass of shift/compare/decimal-accumulate logic in adp_parser.
//   Stall: when the output word is not taken, the input stage still holds
//   one byte; in_ready_o drops only with both stages full and out_ready_i low.
//   Reset: both stages empty, parse state back to the start of a datagram.
//   Parse state also returns to the start after every verdict.

module announcement_datagram_parser #(
  parameter int unsigned MAX_ID_BYTES = adp_pkg::ADP_MAX_ID_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_datagram_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_verdict_o,
  output logic [7:0]  id_byte_o,
  output logic [5:0]  id_index_o,
  output logic        accepted_o,
  output logic [3:0]  reject_reason_o,
  output logic [63:0] generation_o,
  output logic [63:0] sequence_res_o,
  output logic [15:0] rpc_port_o,
  output logic [31:0] ipv4_address_o,
  output logic [5:0]  id_length_o
);
  import adp_pkg::*;

  // Input stage
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;

  // Result stage
  logic        out_valid_q;
  adp_result_t out_q;

  adp_result_t res;
  logic        res_valid;
  logic        advance;   // result stage can take a new word this cycle
  logic        step;      // the held byte is decoded this cycle

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  adp_parser #(
    .MAX_ID_BYTES(MAX_ID_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .data_i     (byte_q),
    .last_i     (last_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && res_valid;
      end
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= end_of_datagram_i;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_verdict_o    = out_q.is_verdict;
  assign id_byte_o       = out_q.id_byte;
  assign id_index_o      = out_q.id_index;
  assign accepted_o      = out_q.accepted;
  assign reject_reason_o = out_q.reason;
  assign generation_o    = out_q.generation;
  assign sequence_res_o  = out_q.sequence_res;
  assign rpc_port_o      = out_q.rpc_port;
  assign ipv4_address_o  = out_q.ipv4_address;
  assign id_length_o     = out_q.id_length;

  // A held byte waits in the input stage while the output stalls
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q) && $stable(last_q))
    else $error("input stage lost a byte during stall");

  a_verdict_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_verdict_o |-> accepted_o == (reject_reason_o == REASON_OK))
    else $error("accepted flag disagrees with reason");

  a_id_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_verdict_o
    |-> !accepted_o && reject_reason_o == REASON_OK && ipv4_address_o == 32'd0)
    else $error("id word carries verdict fields");

endmodule
